// ===== rtl/pdlh_pkg.sv =====
// shared types and constants for the pair distance log histogram
package pdlh_pkg;

  localparam int MAX_BINS_DEF = 32;
  localparam int CNT_W        = 32;
  localparam int COORD_W      = 24;
  localparam int DIFF_W       = 25;
  localparam int SQ_W         = 50;
  localparam int D2_W         = 50;
  localparam int LOG_W        = 23;
  localparam int SCALE_W      = 24;
  localparam int NBIN_W       = 6;
  localparam int BIN_W        = 5;
  localparam int DIFFL_W      = 25;
  localparam int PROD_W       = 50;
  localparam int CFG_IDX_W    = 3;
  localparam int CFG_DATA_W   = 50;
  localparam int IN_DATA_W    = 144;
  localparam int OUT_DATA_W   = 40;

  localparam logic [CFG_IDX_W-1:0] REG_MIN_DIST   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_DIST   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_LOG_SCALE  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BINS       = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQ,
    ST_SUM,
    ST_NORM,
    ST_LOG,
    ST_MUL,
    ST_READ,
    ST_WRITE,
    ST_DUMP,
    ST_CLEAR
  } state_t;

  typedef struct packed {
    logic load;
    logic diff;
    logic sq;
    logic sum;
    logic norm;
    logic log_step;
    logic mul;
    logic rd;
    logic wr_inc;
    logic dump_rd;
    logic clr_wr;
    logic idx_rst;
  } cmd_t;

  typedef struct packed {
    logic keep;
    logic log_done;
    logic bin_ok;
    logic idx_last;
    logic clr_last;
  } sts_t;

endpackage

// ===== rtl/pdlh_ram.sv =====
// generic single-port ram with registered read
module pdlh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// ===== rtl/pdlh_ctrl.sv =====
// sequencer for counting, readout and clearing
module pdlh_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic           in_mode,
  input  logic           out_free,
  input  pdlh_pkg::sts_t sts,
  output pdlh_pkg::cmd_t cmd,
  output logic           busy
);
  import pdlh_pkg::*;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLEAR;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    busy = (state_r != ST_IDLE);
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          cmd.load = 1'b1;
          cmd.idx_rst = 1'b1;
          state_nxt = in_mode ? ST_DUMP : ST_DIFF;
        end
      end
      ST_DIFF: begin cmd.diff = 1'b1; state_nxt = ST_SQ; end
      ST_SQ:   begin cmd.sq = 1'b1; state_nxt = ST_SUM; end
      ST_SUM:  begin cmd.sum = 1'b1; state_nxt = ST_NORM; end
      ST_NORM: begin
        cmd.norm = 1'b1;
        state_nxt = sts.keep ? ST_LOG : ST_IDLE;
      end
      ST_LOG: begin
        cmd.log_step = 1'b1;
        if (sts.log_done) state_nxt = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul = 1'b1;
        state_nxt = ST_READ;
      end
      ST_READ: begin
        if (sts.bin_ok) begin
          cmd.rd = 1'b1;
          state_nxt = ST_WRITE;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_WRITE: begin cmd.wr_inc = 1'b1; state_nxt = ST_IDLE; end
      ST_DUMP: begin
        if (out_free) begin
          cmd.dump_rd = 1'b1;
          if (sts.idx_last) begin
            cmd.idx_rst = 1'b1;
            state_nxt = ST_CLEAR;
          end
        end
      end
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (sts.clr_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && in_fire && !in_mode) |=> state_r == ST_DIFF)
    else $error("count beat did not start arithmetic");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DUMP && out_free && sts.idx_last) |=> state_r == ST_CLEAR)
    else $error("readout did not clear");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wr_inc |-> $past(cmd.rd))
    else $error("increment without read");
endmodule

// ===== rtl/pdlh_datapath.sv =====
// distance, log2, bin index and histogram memory
module pdlh_datapath #(
  parameter int MAX_BINS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  pdlh_pkg::cmd_t                      cmd,
  output pdlh_pkg::sts_t                      sts,
  input  logic [pdlh_pkg::IN_DATA_W-1:0]      in_data,
  input  logic [pdlh_pkg::D2_W-1:0]           min_dist_sq,
  input  logic [pdlh_pkg::D2_W-1:0]           max_dist_sq,
  input  logic signed [pdlh_pkg::LOG_W-1:0]   log_offset,
  input  logic [pdlh_pkg::SCALE_W-1:0]        log_scale,
  input  logic [pdlh_pkg::NBIN_W-1:0]         bins_in_use,
  input  logic                                out_ready,
  output logic                                out_valid,
  output logic [pdlh_pkg::OUT_DATA_W-1:0]     out_data,
  output logic                                out_last,
  output logic                                out_free
);
  import pdlh_pkg::*;

  localparam int AW = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int RD = 1 << AW;
  localparam int IW = AW + 1;

  logic signed [COORD_W-1:0] c_r [6];
  logic signed [DIFF_W-1:0]  d_r [3];
  logic [SQ_W-1:0]           s_r [3];
  logic [D2_W-1:0]           d2_r;
  logic [5:0]                e_r;
  logic [31:0]               m_r;
  logic [15:0]               frac_r;
  logic [4:0]                k_r;
  logic signed [DIFFL_W-1:0] diffl_r;
  logic signed [PROD_W-1:0]  prod_r;
  logic [IW-1:0]             idx_r;
  logic [AW-1:0]             bin_r;
  logic [IW-1:0]             nb;
  logic                      ov_r, ol_r, pend_r;
  logic [BIN_W-1:0]          pb_r;
  logic                      pl_r;

  always_comb begin
    nb = (bins_in_use == '0) ? IW'(1) : IW'(bins_in_use);
    if (int'(bins_in_use) > MAX_BINS) nb = IW'(MAX_BINS);
  end

  always_ff @(posedge clk) begin
    if (cmd.load)
      for (int i = 0; i < 6; i++) c_r[i] <= in_data[COORD_W*i +: COORD_W];
    if (cmd.diff)
      for (int i = 0; i < 3; i++)
        d_r[i] <= DIFF_W'(c_r[i]) - DIFF_W'(c_r[i+3]);
    if (cmd.sq)
      for (int i = 0; i < 3; i++) s_r[i] <= SQ_W'(d_r[i] * d_r[i]);
    if (cmd.sum) d2_r <= s_r[0] + s_r[1] + s_r[2];
  end

  // leading one position and normalize to q1.30
  logic [5:0]  lz_e;
  logic [31:0] lz_m;
  always_comb begin
    lz_e = '0;
    for (int i = 0; i < D2_W; i++) if (d2_r[i]) lz_e = 6'(i);
    if (lz_e > 6'd30) lz_m = 32'(d2_r >> (lz_e - 6'd30));
    else              lz_m = 32'(d2_r << (6'd30 - lz_e));
  end
  logic keep_c;
  assign keep_c = (d2_r > min_dist_sq) && (d2_r < max_dist_sq);

  // one squaring step per cycle
  logic [63:0] sqm;
  logic [33:0] sqs;
  assign sqm = m_r * m_r;
  assign sqs = 34'(sqm >> 30);

  // integer part of the q16 log is the leading one position minus 16
  logic [DIFFL_W-17:0] int_part;
  logic [15:0]         frac_fin;
  assign int_part = (DIFFL_W-16)'(e_r) - (DIFFL_W-16)'(16);
  assign frac_fin = {frac_r[14:0], sqs[31]};

  always_ff @(posedge clk) begin
    if (cmd.norm) begin
      e_r <= lz_e; m_r <= lz_m; frac_r <= '0; k_r <= '0;
    end
    if (cmd.log_step) begin
      k_r <= k_r + 5'd1;
      if (sqs[31]) begin
        m_r <= 32'(sqs >> 1); frac_r <= {frac_r[14:0], 1'b1};
      end else begin
        m_r <= 32'(sqs); frac_r <= {frac_r[14:0], 1'b0};
      end
      if (k_r == 5'd15)
        diffl_r <= $signed({int_part, frac_fin}) - DIFFL_W'(log_offset);
    end
    if (cmd.mul) prod_r <= diffl_r * $signed({1'b0, log_scale});
  end
  assign sts.keep = keep_c;
  assign sts.log_done = (k_r == 5'd15);

  // bin select
  logic [PROD_W-33:0] binw;
  assign binw = prod_r[PROD_W-1:32];
  assign sts.bin_ok = !prod_r[PROD_W-1] && (binw < (PROD_W-32)'(nb));
  assign sts.idx_last = (idx_r == nb - IW'(1));
  assign sts.clr_last = (idx_r == IW'(RD-1));

  // memory
  logic            we;
  logic [AW-1:0]   addr;
  logic [CNT_W-1:0] wdata, rdata;

  assign out_free = !pend_r && (!ov_r || out_ready);

  always_comb begin
    we = cmd.wr_inc || cmd.clr_wr;
    addr = cmd.rd ? AW'(binw) : (cmd.wr_inc ? bin_r : idx_r[AW-1:0]);
    wdata = '0;
    if (cmd.wr_inc) wdata = (rdata == '1) ? rdata : rdata + CNT_W'(1);
  end

  pdlh_ram #(.WIDTH(CNT_W), .DEPTH(RD)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (cmd.rd) bin_r <= AW'(binw);
    if (!rst_n) idx_r <= '0;
    else if (cmd.idx_rst) idx_r <= '0;
    else if (cmd.dump_rd || cmd.clr_wr) idx_r <= idx_r + IW'(1);
  end

  // output register loads in the cycle after the ram read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      pend_r <= cmd.dump_rd;
      if (pend_r) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
    if (cmd.dump_rd) begin
      pb_r <= BIN_W'(idx_r); pl_r <= (idx_r == nb - IW'(1));
    end
    if (pend_r) begin
      out_data <= {2'b0, rdata, 1'b0, pb_r};
      ol_r <= pl_r;
    end
  end
  assign out_valid = ov_r;
  assign out_last = ol_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    pend_r |-> !ov_r || out_ready)
    else $error("output overwritten");
  assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !out_ready |=> ov_r && $stable(out_data) && $stable(ol_r))
    else $error("held beat changed");
  assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.wr_inc && cmd.clr_wr))
    else $error("increment during clear");
endmodule

// ===== rtl/pair_distance_log_histogram.sv =====
// top level of the pair distance log histogram
//  channel | dir | handshake          | payload
//  in      | in  | in_tvalid/tready   | tuser mode, tdata coordinates
//  out     | out | out_tvalid/tready  | tdata bin/count, tlast last bin
//  cfg     | in  | cfg_valid/ready    | cfg_index, cfg_data
// a counted pair runs through diff, square, sum, normalize, 16 one-a-cycle log2
// squaring steps, multiply, ram read and ram write before the next beat is taken;
// a pair outside the window frees the input after normalize, one outside the bins at the bin check.
// a readout takes a ram read, then an output load, for each bin in use, then
// a clearing pass over MAX_BINS (rounded up to a power of two) entries; after reset
// the same pass runs before any beat is taken. a stalled out beat holds the readout.
module pair_distance_log_histogram #(
  parameter int MAX_BINS = pdlh_pkg::MAX_BINS_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // first_x, first_y, first_z, second_x, second_y, second_z
  input  logic [pdlh_pkg::IN_DATA_W-1:0]     in_tdata,
  // mode
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // bin_number, doubled_count, zero pad
  output logic [pdlh_pkg::OUT_DATA_W-1:0]    out_tdata,
  output logic                               out_tlast,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [pdlh_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pdlh_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import pdlh_pkg::*;

  logic [D2_W-1:0]           min_r, max_r;
  logic signed [LOG_W-1:0]   off_r;
  logic [SCALE_W-1:0]        scl_r;
  logic [NBIN_W-1:0]         nb_r;
  cmd_t cmd;
  sts_t sts;
  logic busy, out_free, in_fire;

  assign cfg_ready = 1'b1;
  assign in_tready = !busy;
  assign in_fire = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r <= D2_W'(1); max_r <= '1; off_r <= '0;
      scl_r <= SCALE_W'(65536); nb_r <= NBIN_W'(32);
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_MIN_DIST:   min_r <= cfg_data;
        REG_MAX_DIST:   max_r <= cfg_data;
        REG_LOG_OFFSET: off_r <= cfg_data[LOG_W-1:0];
        REG_LOG_SCALE:  scl_r <= cfg_data[SCALE_W-1:0];
        REG_BINS:       nb_r <= cfg_data[NBIN_W-1:0];
        default: ;
      endcase
    end
  end

  pdlh_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_fire(in_fire), .in_mode(in_tuser),
    .out_free(out_free), .sts(sts), .cmd(cmd), .busy(busy)
  );

  pdlh_datapath #(.MAX_BINS(MAX_BINS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .in_data(in_tdata),
    .min_dist_sq(min_r), .max_dist_sq(max_r), .log_offset(off_r),
    .log_scale(scl_r), .bins_in_use(nb_r), .out_ready(out_tready),
    .out_valid(out_tvalid), .out_data(out_tdata), .out_last(out_tlast),
    .out_free(out_free)
  );
endmodule

// ===== dv/pair_distance_log_histogram_tb.sv =====
// self-checking testbench for the pair distance log histogram
`timescale 1ns / 1ps

module pair_distance_log_histogram_tb;
  import pdlh_pkg::*;

  localparam longint unsigned MASK50 = 64'h3_FFFF_FFFF_FFFF;
  localparam int NBINS = MAX_BINS_DEF;

  typedef struct {
    bit mode;
    logic signed [COORD_W-1:0] ax, ay, az, bx, by, bz;
  } pair_t;

  typedef struct {
    bit [BIN_W-1:0] bin;
    bit [32:0]      dcount;
    bit             last;
  } bin_beat_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic out_tlast;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  pair_distance_log_histogram dut (.*);

  always #5 clk = ~clk;

  // predictor state
  bit [49:0] win_lo = 50'd1;
  bit [49:0] win_hi = MASK50[49:0];
  logic signed [LOG_W-1:0] log_off = '0;
  bit [SCALE_W-1:0] log_scl = 24'd65536;
  bit [NBIN_W-1:0] bins_cfg = 6'd32;
  bit [31:0] hist [NBINS];

  pair_t pair_q[$];
  bin_beat_t readout_q[$];
  pair_t cur_pair;
  int errors = 0;
  int queued = 0;
  int pairs_sent = 0, readouts_sent = 0, beats_seen = 0;
  int in_gap = 0, out_gap = 0;
  bit quiet = 1'b0;
  bit long_stall_req = 1'b0;
  logic out_hold = 1'b0;

  function automatic void add_pair(pair_t p);
    pair_q.insert(pair_q.size(), p);
    queued++;
  endfunction

  function automatic longint log2_q16(longint unsigned v);
    int e;
    longint unsigned m;
    longint frac;
    e = 63;
    frac = 0;
    while (e > 0 && v[e] == 1'b0) e--;
    if (e > 30) m = v >> (e - 30);
    else m = v << (30 - e);
    for (int k = 0; k < 16; k++) begin
      m = (m * m) >> 30;
      frac = frac << 1;
      if (m >= 64'h8000_0000) begin
        frac = frac | 1;
        m = m >> 1;
      end
    end
    return (longint'(e) - 16) * 65536 + frac;
  endfunction

  function automatic int active_bins();
    if (bins_cfg == 0) return 1;
    if (bins_cfg > NBINS) return NBINS;
    return int'(bins_cfg);
  endfunction

  function automatic void apply_pair(pair_t p);
    longint dx, dy, dz, diff, prod;
    longint unsigned d2;
    int nb;
    bin_beat_t b;
    nb = active_bins();
    if (p.mode) begin
      for (int i = 0; i < nb; i++) begin
        b.bin = i[BIN_W-1:0];
        b.dcount = {hist[i], 1'b0};
        b.last = (i == nb - 1);
        readout_q.insert(readout_q.size(), b);
      end
      foreach (hist[i]) hist[i] = '0;
      return;
    end
    dx = longint'(p.ax) - longint'(p.bx);
    dy = longint'(p.ay) - longint'(p.by);
    dz = longint'(p.az) - longint'(p.bz);
    d2 = dx * dx + dy * dy + dz * dz;
    if (!(d2 > {14'd0, win_lo} && d2 < {14'd0, win_hi})) return;
    diff = log2_q16(d2) - longint'(log_off);
    prod = diff * longint'({40'd0, log_scl});
    if (prod < 0) return;
    if ((prod >>> 32) >= nb) return;
    if (hist[prod >>> 32] != 32'hFFFF_FFFF) hist[prod >>> 32]++;
  endfunction

  // input driver
  always @(posedge clk) begin
    bit take;
    bit nv;
    pair_t nxt;
    take = in_tvalid && in_tready;
    nv = in_tvalid;
    nxt = cur_pair;
    if (rst_n) begin
      if (take) begin
        apply_pair(cur_pair);
        if (cur_pair.mode) readouts_sent++;
        else pairs_sent++;
      end
      if (!in_tvalid || take) begin
        nv = 1'b0;
        if (in_gap > 0) begin
          in_gap--;
        end else if (pair_q.size() != 0) begin
          if (!quiet && $urandom_range(0, 7) == 0) begin
            in_gap = $urandom_range(1, 16) - 1;
          end else begin
            nxt = pair_q.pop_front();
            nv = 1'b1;
          end
        end
      end
    end
    cur_pair = nxt;
    in_tvalid <= nv;
    in_tuser <= nxt.mode;
    in_tdata <= {nxt.bz, nxt.by, nxt.bx, nxt.az, nxt.ay, nxt.ax};
  end

  // result monitor
  always @(posedge clk) begin
    bin_beat_t exp_b;
    bit rdy;
    if (rst_n && out_tvalid && out_tready) begin
      beats_seen++;
      if (readout_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected beat: bin %0d count %0d last %0b",
                   out_tdata[4:0], out_tdata[37:5], out_tlast);
      end else begin
        exp_b = readout_q.pop_front();
        if (out_tdata[4:0] !== exp_b.bin || out_tdata[37:5] !== exp_b.dcount ||
            out_tlast !== exp_b.last) begin
          errors++;
          if (errors <= 10)
            $display("beat mismatch: exp bin %0d count %0d last %0b, %s",
                     exp_b.bin, exp_b.dcount, exp_b.last,
                     $sformatf("got bin %0d count %0d last %0b",
                               out_tdata[4:0], out_tdata[37:5], out_tlast));
        end
      end
    end
    rdy = 1'b1;
    if (out_hold) begin
      rdy = 1'b0;
    end else if (out_gap > 0) begin
      out_gap--;
      rdy = 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(1, 16) - 1;
      rdy = 1'b0;
    end
    out_tready <= rdy;
  end

  // long receiver stall so the block backs up and drops in_tready
  initial begin
    wait (long_stall_req);
    @(posedge clk);
    out_hold <= 1'b1;
    repeat (400) @(posedge clk);
    out_hold <= 1'b0;
  end

  initial begin
    #5ms;
    $display("pair_distance_log_histogram: mismatch");
    $finish;
  end

  function automatic pair_t make_pair(bit mode, longint a0, a1, a2, b0, b1, b2);
    pair_t p;
    p.mode = mode;
    p.ax = a0[23:0]; p.ay = a1[23:0]; p.az = a2[23:0];
    p.bx = b0[23:0]; p.by = b1[23:0]; p.bz = b2[23:0];
    return p;
  endfunction

  function automatic longint near_coord(longint c);
    longint d;
    longint r;
    d = longint'($urandom) & ((64'd1 << $urandom_range(0, 23)) - 1);
    if ($urandom_range(0, 1)) d = -d;
    r = c + d;
    if (r > 8388607 || r < -8388608) r = c - d;
    return r;
  endfunction

  task automatic push_random(int n);
    pair_t p;
    longint a0, a1, a2;
    for (int i = 0; i < n; i++) begin
      a0 = $signed($urandom_range(0, 24'hFFFFFF) - 8388608);
      a1 = $signed($urandom_range(0, 24'hFFFFFF) - 8388608);
      a2 = $signed($urandom_range(0, 24'hFFFFFF) - 8388608);
      case ($urandom_range(0, 9))
        0: p = make_pair(1'b1, a0, a1, a2, a0 ^ 1, a1, a2);
        1: p = make_pair(1'b0, a0, a1, a2,
                         $signed($urandom_range(0, 24'hFFFFFF) - 8388608),
                         $signed($urandom_range(0, 24'hFFFFFF) - 8388608),
                         $signed($urandom_range(0, 24'hFFFFFF) - 8388608));
        default: p = make_pair(1'b0, a0, a1, a2, near_coord(a0), near_coord(a1),
                               near_coord(a2));
      endcase
      add_pair(p);
    end
    add_pair(make_pair(1'b1, 0, 0, 0, 0, 0, 0));
  endtask

  // wait until every queued beat was taken and its readout drained
  task automatic drain();
    while (pairs_sent + readouts_sent != queued) @(posedge clk);
    while (readout_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  // assumes the caller sits right after a rising edge
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, longint unsigned val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[49:0];
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MIN_DIST:   win_lo = val[49:0];
      REG_MAX_DIST:   win_hi = val[49:0];
      REG_LOG_OFFSET: log_off = val[22:0];
      REG_LOG_SCALE:  log_scl = val[23:0];
      REG_BINS:       bins_cfg = val[5:0];
      default: ;
    endcase
  endtask

  task automatic set_all(longint unsigned lo, longint unsigned hi, longint off,
                         longint unsigned scl, longint unsigned nb);
    write_reg(REG_MIN_DIST, lo);
    write_reg(REG_MAX_DIST, hi);
    write_reg(REG_LOG_OFFSET, longint'(off) & 64'h7FFFFF);
    write_reg(REG_LOG_SCALE, scl);
    write_reg(REG_BINS, nb);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    foreach (hist[i]) hist[i] = '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: extremes, zero distance, sub-unit and unit distances, readouts
    add_pair(make_pair(1'b0, 8388607, 8388607, 8388607,
                       -8388608, -8388608, -8388608));
    add_pair(make_pair(1'b0, -8388608, -8388608, -8388608,
                       -8388608, -8388608, -8388608));
    add_pair(make_pair(1'b0, 5, 5, 5, 6, 5, 5));
    add_pair(make_pair(1'b0, 5, 5, 5, 7, 5, 5));
    add_pair(make_pair(1'b0, 0, 0, 0, 256, 0, 0));
    add_pair(make_pair(1'b0, 0, 0, 0, 256, 256, 256));
    add_pair(make_pair(1'b0, 100, -100, 0, 100 + 4096, -100, 0));
    add_pair(make_pair(1'b0, 0, 0, 0, 0, 0, 8388607));
    add_pair(make_pair(1'b0, 8388607, 0, 0, -8388608, 0, 0));
    add_pair(make_pair(1'b1, 8388607, 8388607, 8388607,
                       -8388608, -8388608, -8388608));
    add_pair(make_pair(1'b1, 0, 0, 0, 0, 0, 0));
    add_pair(make_pair(1'b0, 0, 0, 0, 65536, 0, 0));
    add_pair(make_pair(1'b1, -1, -1, -1, -1, -1, -1));
    push_random(30);
    drain();

    // a readout first, so the long receiver stall backs up the input
    set_all(64'd65536, 64'd1 << 40, 2 * 65536, 2 * 65536, 20);
    long_stall_req = 1'b1;
    add_pair(make_pair(1'b1, 0, 0, 0, 0, 0, 0));
    push_random(45);
    drain();

    // empty window, steepest scale, bins of zero
    set_all(MASK50, 1, -3276800, 24'hFFFFFF, 0);
    push_random(25);
    drain();

    // zero scale puts every pair inside the window into bin zero
    set_all(0, MASK50, -3276800, 0, 63);
    push_random(35);
    drain();

    set_all(1, 64'd1 << 46, 3276800, 1, 1);
    push_random(20);
    drain();

    quiet = 1'b1;
    set_all(1, 64'd1 << 46, -524288, 98304, 32);
    push_random(45);
    drain();

    $display("covered %0d pairs and %0d readouts (%0d bin beats), six register sets",
             pairs_sent, readouts_sent, beats_seen);
    $display("incl. an empty window, zero scale, and bin counts of 0, 1, 20, 32 and 63");
    if (errors == 0 && readout_q.size() == 0) begin
      $display("pair_distance_log_histogram: match");
    end else begin
      $display("pair_distance_log_histogram: mismatch");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/pdlh_pkg.sv
rtl/pdlh_ram.sv
rtl/pdlh_ctrl.sv
rtl/pdlh_datapath.sv
rtl/pair_distance_log_histogram.sv
dv/pair_distance_log_histogram_tb.sv
